FILE: hdl/biq_pkg.sv
// Shared constants, codes and types for the biquad section.
`timescale 1ns / 1ps

package biq_pkg;

    localparam int COEF_W         = 16;
    localparam int SAMPLE_W       = 32;
    localparam int OUT_W          = 29;
    localparam int FRAC_BITS_DEF  = 13;
    localparam int STATE_BITS_DEF = 25;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic signed [COEF_W-1:0] COEF_UNITY_RST = 16'sd8192;
    localparam logic signed [COEF_W-1:0] COEF_ZERO_RST  = 16'sd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A0 = 3'd3,
        REG_A1 = 3'd4,
        REG_A2 = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        logic    mul_en;
        acc_op_t op;
    } mac_ctrl_t;

endpackage

FILE: hdl/biq_stream_if.sv
// Valid/ready stream interfaces for input and output sample words.
`timescale 1ns / 1ps

interface biq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [biq_pkg::SAMPLE_W-1:0]  sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface biq_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [biq_pkg::OUT_W-1:0]     sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: hdl/biq_mac.sv
// Shared multiplier with registered product and shifted accumulate stage.
`timescale 1ns / 1ps

module biq_mac #(
    parameter int COEF_FRAC_BITS = biq_pkg::FRAC_BITS_DEF,
    parameter int STATE_BITS     = biq_pkg::STATE_BITS_DEF
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  biq_pkg::mac_ctrl_t                                  ctrl,
    input  logic signed [biq_pkg::COEF_W-1:0]                   coef,
    input  logic signed [STATE_BITS-1:0]                        operand,
    output logic signed [biq_pkg::COEF_W+STATE_BITS+1:0]        acc
);

    localparam int PROD_W = biq_pkg::COEF_W + STATE_BITS;
    localparam int ACC_W  = PROD_W + 2;

    logic signed [PROD_W-1:0] product;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     pend_reg;
    biq_pkg::acc_op_t         op_reg;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    assign product = coef * operand;
    assign term    = ACC_W'(prod_reg >>> COEF_FRAC_BITS);

    always_comb
    begin
        case (op_reg)
            biq_pkg::ACC_LOAD: acc_next = term;
            biq_pkg::ACC_ADD:  acc_next = acc_reg + term;
            biq_pkg::ACC_SUB:  acc_next = acc_reg - term;
            default:           acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            op_reg   <= biq_pkg::ACC_LOAD;
        end
        else
        begin
            pend_reg <= ctrl.mul_en;
            if (ctrl.mul_en)
            begin
                op_reg <= ctrl.op;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= product;
        end
        if (pend_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

FILE: hdl/biquad_iir_direct_form_two.sv
// Biquad IIR section, direct form II, over one shared multiply-accumulate unit.
//
//   channel   direction  handshake          payload
//   in_ch     in         valid / ready      sample_in  (32 bit signed)
//   out_ch    out        valid / ready      sample_out (29 bit signed)
//   cfg       in         cfg_we, no stall   cfg_index (3 bit), cfg_data (16 bit)
//
// Each word runs six products through the single multiplier plus drain, saturate and hand-off
// steps before the next word can be accepted.
// in_ch.ready is high only while idle; one word is in flight at a time.
// A result waiting on out_ch holds the sequencer in its last step.
// Reset clears the delay line, the coefficients to their defaults and all control.
`timescale 1ns / 1ps

module biquad_iir_direct_form_two #(
    parameter int COEF_FRAC_BITS = biq_pkg::FRAC_BITS_DEF,
    parameter int STATE_BITS     = biq_pkg::STATE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    biq_in_if.sink                            in_ch,
    biq_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [biq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [biq_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ACC_W = biq_pkg::COEF_W + STATE_BITS + 2;
    localparam logic signed [ACC_W-1:0] ST_HI =
        ACC_W'((64'sd1 <<< (STATE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] ST_LO =
        ACC_W'(-(64'sd1 <<< (STATE_BITS - 1)));
    localparam logic [1:0] LAST_STEP = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_A,
        S_DRAIN_A,
        S_SAT,
        S_MUL_B,
        S_DRAIN_B,
        S_FIN
    } state_t;

    state_t                            state_reg;
    logic [1:0]                        step_reg;
    logic signed [STATE_BITS-1:0]      x_reg;
    logic signed [STATE_BITS-1:0]      w0_reg;
    logic signed [STATE_BITS-1:0]      w1_reg;
    logic signed [STATE_BITS-1:0]      w2_reg;
    logic                              out_valid_reg;
    logic signed [biq_pkg::OUT_W-1:0]  out_sample_reg;

    logic signed [biq_pkg::COEF_W-1:0] b0_reg, b1_reg, b2_reg;
    logic signed [biq_pkg::COEF_W-1:0] a0_reg, a1_reg, a2_reg;

    biq_pkg::mac_ctrl_t                mac_ctrl;
    logic signed [biq_pkg::COEF_W-1:0] mac_coef;
    logic signed [STATE_BITS-1:0]      mac_operand;
    logic signed [ACC_W-1:0]           mac_acc;
    logic                              in_fire;
    logic                              out_free;
    logic                              out_load;

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] r;
        begin
            if (v > ST_HI)
                r = ST_HI;
            else if (v < ST_LO)
                r = ST_LO;
            else
                r = v;
            return r[STATE_BITS-1:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg <= biq_pkg::COEF_UNITY_RST;
            b1_reg <= biq_pkg::COEF_ZERO_RST;
            b2_reg <= biq_pkg::COEF_ZERO_RST;
            a0_reg <= biq_pkg::COEF_UNITY_RST;
            a1_reg <= biq_pkg::COEF_ZERO_RST;
            a2_reg <= biq_pkg::COEF_ZERO_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                biq_pkg::REG_B0: b0_reg <= cfg_data;
                biq_pkg::REG_B1: b1_reg <= cfg_data;
                biq_pkg::REG_B2: b2_reg <= cfg_data;
                biq_pkg::REG_A0: a0_reg <= cfg_data;
                biq_pkg::REG_A1: a1_reg <= cfg_data;
                biq_pkg::REG_A2: a2_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Select factor pair and accumulate operation for the current product.
    always_comb
    begin
        mac_ctrl.mul_en = 1'b0;
        mac_ctrl.op     = biq_pkg::ACC_LOAD;
        mac_coef        = a0_reg;
        mac_operand     = x_reg;
        case (state_reg)
            S_MUL_A:
            begin
                mac_ctrl.mul_en = 1'b1;
                case (step_reg)
                    2'd0:
                    begin
                        mac_ctrl.op = biq_pkg::ACC_LOAD;
                        mac_coef    = a0_reg;
                        mac_operand = x_reg;
                    end
                    2'd1:
                    begin
                        mac_ctrl.op = biq_pkg::ACC_SUB;
                        mac_coef    = a1_reg;
                        mac_operand = w1_reg;
                    end
                    default:
                    begin
                        mac_ctrl.op = biq_pkg::ACC_SUB;
                        mac_coef    = a2_reg;
                        mac_operand = w2_reg;
                    end
                endcase
            end
            S_MUL_B:
            begin
                mac_ctrl.mul_en = 1'b1;
                case (step_reg)
                    2'd0:
                    begin
                        mac_ctrl.op = biq_pkg::ACC_LOAD;
                        mac_coef    = b0_reg;
                        mac_operand = w0_reg;
                    end
                    2'd1:
                    begin
                        mac_ctrl.op = biq_pkg::ACC_ADD;
                        mac_coef    = b1_reg;
                        mac_operand = w1_reg;
                    end
                    default:
                    begin
                        mac_ctrl.op = biq_pkg::ACC_ADD;
                        mac_coef    = b2_reg;
                        mac_operand = w2_reg;
                    end
                endcase
            end
            default: ;
        endcase
    end

    biq_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .STATE_BITS     (STATE_BITS)
    ) u_biq_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .coef    (mac_coef),
        .operand (mac_operand),
        .acc     (mac_acc)
    );

    assign in_fire  = in_ch.valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign out_load = (state_reg == S_FIN) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= 2'd0;
            x_reg          <= '0;
            w0_reg         <= '0;
            w1_reg         <= '0;
            w2_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_sample_reg <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        x_reg     <= sat_state(ACC_W'(in_ch.sample_in));
                        step_reg  <= 2'd0;
                        state_reg <= S_MUL_A;
                    end
                end
                S_MUL_A:
                begin
                    if (step_reg == LAST_STEP)
                    begin
                        step_reg  <= 2'd0;
                        state_reg <= S_DRAIN_A;
                    end
                    else
                    begin
                        step_reg <= step_reg + 2'd1;
                    end
                end
                S_DRAIN_A:
                begin
                    state_reg <= S_SAT;
                end
                S_SAT:
                begin
                    w0_reg    <= sat_state(mac_acc);
                    state_reg <= S_MUL_B;
                end
                S_MUL_B:
                begin
                    if (step_reg == LAST_STEP)
                    begin
                        step_reg  <= 2'd0;
                        state_reg <= S_DRAIN_B;
                    end
                    else
                    begin
                        step_reg <= step_reg + 2'd1;
                    end
                end
                S_DRAIN_B:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_sample_reg <= mac_acc[biq_pkg::OUT_W-1:0];
                        w2_reg         <= w1_reg;
                        w1_reg         <= w0_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = out_sample_reg;

endmodule

FILE: hdl/biq_checker.sv
// Port-level checks for the biquad section, bound to the top level.
`timescale 1ns / 1ps

module biq_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [biq_pkg::OUT_W-1:0]  out_sample
);

    logic in_fire;

    assign in_fire = in_valid && in_ready;

    // a stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("output word dropped or changed while stalled");

    // an accepted word keeps the input closed through the first multiply pass and its drain step
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input reopened while a word is in flight");

    // a result is presented exactly when the sequencer returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $rose(in_ready))
    else $error("result presented without finishing a word");

    // the input never reopens without a result having been produced
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid)
    else $error("word finished without a result");

endmodule

bind biquad_iir_direct_form_two biq_checker u_biq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_sample (out_ch.sample_out)
);

FILE: tb/tb_top.sv
// Self-checking testbench for the direct form II biquad section over random stalls.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [biq_pkg::CFG_IDX_W-1:0]    IDX_SPARE_A = 3'd6;
    localparam logic [biq_pkg::CFG_IDX_W-1:0]    IDX_SPARE_B = 3'd7;
    localparam logic signed [biq_pkg::OUT_W-1:0] SAT_HI      = 29'sd16777215;
    localparam logic signed [biq_pkg::OUT_W-1:0] SAT_LO      = -29'sd16777216;
    localparam logic [biq_pkg::COEF_W-1:0]       COEF_MIN    = 16'h8000;
    localparam logic [biq_pkg::COEF_W-1:0]       COEF_MAX    = 16'h7FFF;
    localparam int                               RANDOM_WORDS = 1800;

    typedef struct packed {
        logic                              load;
        logic [biq_pkg::COEF_W-1:0]        coef_all;
        logic [biq_pkg::SAMPLE_W-1:0]      stim;
        logic                              known;
        logic signed [biq_pkg::OUT_W-1:0]  want;
    } sample_row_t;

    sample_row_t directed_rows [23] = '{
        '{1'b0, 16'h0000, 32'h0000_0000, 1'b1, 29'sd0},
        '{1'b0, 16'h0000, 32'h0000_0001, 1'b1, 29'sd1},
        '{1'b0, 16'h0000, 32'hFFFF_FFFF, 1'b1, -29'sd1},
        '{1'b0, 16'h0000, 32'h00FF_FFFF, 1'b1, SAT_HI},
        '{1'b0, 16'h0000, 32'h0100_0000, 1'b1, SAT_HI},
        '{1'b0, 16'h0000, 32'hFF00_0000, 1'b1, SAT_LO},
        '{1'b0, 16'h0000, 32'hFEFF_FFFF, 1'b1, SAT_LO},
        '{1'b0, 16'h0000, 32'h7FFF_FFFF, 1'b1, SAT_HI},
        '{1'b0, 16'h0000, 32'h8000_0000, 1'b1, SAT_LO},
        '{1'b0, 16'h0000, 32'h5555_5555, 1'b1, SAT_HI},
        '{1'b0, 16'h0000, 32'hAAAA_AAAA, 1'b1, SAT_LO},
        '{1'b0, 16'h0000, 32'h00AA_AAAA, 1'b1, 29'sh0AA_AAAA},
        '{1'b0, 16'h0000, 32'hFF55_5555, 1'b1, 29'sh1F55_5555},
        '{1'b1, COEF_MIN, 32'h7FFF_FFFF, 1'b0, 29'sd0},
        '{1'b0, 16'h0000, 32'h8000_0000, 1'b0, 29'sd0},
        '{1'b0, 16'h0000, 32'h7FFF_FFFF, 1'b0, 29'sd0},
        '{1'b0, 16'h0000, 32'h0000_0000, 1'b0, 29'sd0},
        '{1'b0, 16'h0000, 32'h0000_0000, 1'b0, 29'sd0},
        '{1'b1, COEF_MAX, 32'h7FFF_FFFF, 1'b0, 29'sd0},
        '{1'b0, 16'h0000, 32'h8000_0000, 1'b0, 29'sd0},
        '{1'b0, 16'h0000, 32'hFFFF_FFFF, 1'b0, 29'sd0},
        '{1'b0, 16'h0000, 32'h0000_0001, 1'b0, 29'sd0},
        '{1'b0, 16'h0000, 32'h0000_0000, 1'b0, 29'sd0}
    };

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                cfg_we;
    logic [biq_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [biq_pkg::CFG_DATA_W-1:0]      cfg_data;

    biq_in_if  in_ch ();
    biq_out_if out_ch ();

    logic signed [biq_pkg::COEF_W-1:0]          coef_mirror [6];
    logic signed [biq_pkg::STATE_BITS_DEF-1:0]  w_one;
    logic signed [biq_pkg::STATE_BITS_DEF-1:0]  w_two;
    logic signed [biq_pkg::OUT_W-1:0]           expected_out [$];
    int                                         mismatches = 0;
    bit                                         tx_calm = 1'b0;
    bit                                         rx_calm = 1'b0;

    biquad_iir_direct_form_two i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint clamp_state(input longint v);
        longint hi;
        hi = (longint'(1) <<< (biq_pkg::STATE_BITS_DEF - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic longint q13_term(input logic signed [biq_pkg::COEF_W-1:0] c,
                                        input longint v);
        return (longint'(c) * v) >>> biq_pkg::FRAC_BITS_DEF;
    endfunction

    // advance the mirrored delay line by one sample
    function automatic logic signed [biq_pkg::OUT_W-1:0] filter_step(
        input logic signed [biq_pkg::SAMPLE_W-1:0] s
    );
        longint x;
        longint w0;
        longint y;
        x  = clamp_state(longint'(s));
        w0 = clamp_state(q13_term(coef_mirror[biq_pkg::REG_A0], x)
                         - q13_term(coef_mirror[biq_pkg::REG_A1], longint'(w_one))
                         - q13_term(coef_mirror[biq_pkg::REG_A2], longint'(w_two)));
        y  = q13_term(coef_mirror[biq_pkg::REG_B0], w0)
             + q13_term(coef_mirror[biq_pkg::REG_B1], longint'(w_one))
             + q13_term(coef_mirror[biq_pkg::REG_B2], longint'(w_two));
        w_two = w_one;
        w_one = w0[biq_pkg::STATE_BITS_DEF-1:0];
        return y[biq_pkg::OUT_W-1:0];
    endfunction

    task automatic write_coef(input logic [biq_pkg::CFG_IDX_W-1:0] idx,
                              input logic [biq_pkg::COEF_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        if (idx <= biq_pkg::REG_A2)
            coef_mirror[idx] = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic push_sample(input logic [biq_pkg::SAMPLE_W-1:0] s, input bit known,
                               input logic signed [biq_pkg::OUT_W-1:0] want);
        int                                gap;
        logic signed [biq_pkg::OUT_W-1:0]  predicted;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.sample_in = s;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predicted = filter_step(s);
        expected_out.push_back(known ? want : predicted);
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int                                stall;
        logic signed [biq_pkg::OUT_W-1:0]  want;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = rx_calm ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            if (expected_out.size() == 0)
            begin
                $display("%0t: unexpected word, sample_out %0d", $time, out_ch.sample_out);
                mismatches++;
            end
            else
            begin
                want = expected_out.pop_front();
                if (out_ch.sample_out !== want)
                begin
                    $display("%0t: sample_out expected %0d, got %0d",
                             $time, want, out_ch.sample_out);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #6_000_000;
        $display("** biquad_iir_direct_form_two: FAILED **");
        $finish;
    end

    initial
    begin
        int                             words_sent;
        int                             phase_len;
        int                             mode;
        int                             pick;
        biq_pkg::cfg_reg_t              reg_id;
        logic [biq_pkg::COEF_W-1:0]     c;
        logic [biq_pkg::SAMPLE_W-1:0]   s;
        logic [biq_pkg::SAMPLE_W-1:0]   prev_s;
        logic [31:0]                    r;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.sample_in = '0;
        coef_mirror[biq_pkg::REG_B0] = biq_pkg::COEF_UNITY_RST;
        coef_mirror[biq_pkg::REG_B1] = biq_pkg::COEF_ZERO_RST;
        coef_mirror[biq_pkg::REG_B2] = biq_pkg::COEF_ZERO_RST;
        coef_mirror[biq_pkg::REG_A0] = biq_pkg::COEF_UNITY_RST;
        coef_mirror[biq_pkg::REG_A1] = biq_pkg::COEF_ZERO_RST;
        coef_mirror[biq_pkg::REG_A2] = biq_pkg::COEF_ZERO_RST;
        w_one  = '0;
        w_two  = '0;
        prev_s = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].load)
            begin
                drain();
                for (int k = 0; k < 6; k++)
                    write_coef(k[biq_pkg::CFG_IDX_W-1:0], directed_rows[i].coef_all);
            end
            push_sample(directed_rows[i].stim, directed_rows[i].known, directed_rows[i].want);
        end

        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            drain();
            mode    = $urandom_range(0, 3);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 6; k++)
            begin
                reg_id = biq_pkg::cfg_reg_t'(k);
                r      = $urandom;
                case (mode)
                    0: c = r[15:0];
                    1: c = (reg_id == biq_pkg::REG_A0) ? biq_pkg::COEF_UNITY_RST
                                                       : 16'($signed(r[14:0]) >>> 1);
                    2:
                    begin
                        pick = $urandom_range(0, 5);
                        case (pick)
                            0: c = COEF_MIN;
                            1: c = COEF_MAX;
                            2: c = biq_pkg::COEF_ZERO_RST;
                            3: c = biq_pkg::COEF_UNITY_RST;
                            4: c = -biq_pkg::COEF_UNITY_RST;
                            default: c = r[15:0];
                        endcase
                    end
                    default: c = (reg_id == biq_pkg::REG_B0 || reg_id == biq_pkg::REG_A0)
                                 ? biq_pkg::COEF_UNITY_RST : biq_pkg::COEF_ZERO_RST;
                endcase
                write_coef(reg_id, c);
            end
            r = $urandom;
            write_coef(r[0] ? IDX_SPARE_A : IDX_SPARE_B, r[31:16]);

            phase_len = $urandom_range(100, 300);
            if (phase_len > RANDOM_WORDS - words_sent)
                phase_len = RANDOM_WORDS - words_sent;
            repeat (phase_len)
            begin
                r    = $urandom;
                pick = $urandom_range(0, 9);
                case (pick)
                    0, 1: s = r;
                    2, 3, 4, 5, 6: s = {{7{r[24]}}, r[24:0]};
                    7: s = 32'($signed($urandom_range(0, 8192)) - 4096);
                    8:
                    begin
                        case (r[1:0])
                            2'd0: s = 32'h7FFF_FFFF;
                            2'd1: s = 32'h8000_0000;
                            2'd2: s = 32'h00FF_FFFF;
                            default: s = 32'hFF00_0000;
                        endcase
                    end
                    default: s = prev_s;
                endcase
                prev_s = s;
                push_sample(s, 1'b0, '0);
                words_sent++;
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("** biquad_iir_direct_form_two: PASSED **");
        else
            $display("** biquad_iir_direct_form_two: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
hdl/biq_pkg.sv
hdl/biq_stream_if.sv
hdl/biq_mac.sv
hdl/biquad_iir_direct_form_two.sv
hdl/biq_checker.sv
tb/tb_top.sv
